@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define T2P_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("track2 parser check failed");

// Next-cycle implication, disabled while reset is high.
`define T2P_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("track2 parser check failed");

`endif

@@ hdl/t2p_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t2p_pkg
// Types, constants and the per-nibble step of the Track 2 parser.
// ----------------------------------------------------------------------------
package t2p_pkg;

   localparam int MAX_PAN_DIGITS  = 19;
   localparam int COUNT_W         = 5;
   localparam int MIN_PAN_DIGITS  = 8;
   localparam int TRAILER_NIBBLES = 7;
   localparam int EXPIRY_NIBBLES  = 4;
   localparam int MONTH_MAX       = 12;

   localparam logic [3:0] DIGIT_MAX  = 4'd9;
   localparam logic [3:0] SEP_NIBBLE = 4'hD;

   // parse phases
   localparam logic [1:0] PH_ACCOUNT = 2'd0;
   localparam logic [1:0] PH_TRAILER = 2'd1;
   localparam logic [1:0] PH_DONE    = 2'd2;

   // result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_SHORT = 2'd1;
   localparam logic [1:0] ST_LONG  = 2'd2;

   // trailer error bits
   localparam logic [1:0] BAD_EXPIRY  = 2'b01;
   localparam logic [1:0] BAD_SERVICE = 2'b10;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } req_beat_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [4:0]  pan_length;
      logic [63:0] pan_bcd_low;
      logic [11:0] pan_bcd_high;
      logic        luhn_ok;
      logic        separator_seen;
      logic        expiry_valid;
      logic [6:0]  expiry_year;
      logic [3:0]  expiry_month;
      logic        service_valid;
      logic [11:0] service_code_bcd;
   } rsp_beat_type;

   typedef logic [MAX_PAN_DIGITS-1:0][3:0] pan_digits_type;

   typedef struct packed {
      logic [1:0]         phase;
      logic [COUNT_W-1:0] digit_count;
      logic [3:0]         luhn_even;
      logic [3:0]         luhn_odd;
      logic [2:0]         field_pos;
      logic [27:0]        trailer;
      logic [1:0]         trailer_bad;
      logic               overflow;
      logic               separator;
   } rec_state_type;

   typedef struct packed {
      rec_state_type      st;
      logic               wr;
      logic [COUNT_W-1:0] idx;
   } nib_step_type;

   localparam rec_state_type REC_CLEAR = '{
      phase: PH_ACCOUNT, digit_count: '0, luhn_even: '0, luhn_odd: '0,
      field_pos: '0, trailer: '0, trailer_bad: '0, overflow: 1'b0,
      separator: 1'b0};

   // add two decimal digits mod 10
   function automatic logic [3:0] mod10_add(logic [3:0] a, logic [3:0] b);
      logic [4:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= 5'd10) begin
         s = s - 5'd10;
      end
      return s[3:0];
   endfunction

   // Luhn doubling: 2n, minus 9 when it passes 9
   function automatic logic [3:0] luhn_double(logic [3:0] n);
      logic [4:0] d;
      d = {n, 1'b0};
      if (d > 5'd9) begin
         d = d - 5'd9;
      end
      return d[3:0];
   endfunction

   // times ten on a decimal digit
   function automatic logic [6:0] times_ten(logic [3:0] n);
      return {n, 3'b000} + {2'b00, n, 1'b0};
   endfunction

   // advance the record by one nibble
   function automatic nib_step_type take_nibble(rec_state_type s, logic [3:0] n);
      nib_step_type r;
      logic [3:0]   dbl;
      logic [2:0]   fp;
      r     = '{st: s, wr: 1'b0, idx: s.digit_count};
      dbl   = luhn_double(n);
      fp    = s.field_pos;
      unique case (s.phase)
         PH_ACCOUNT: begin
            if (n == SEP_NIBBLE) begin
               r.st.separator = 1'b1;
               r.st.phase     = PH_TRAILER;
               r.st.field_pos = '0;
            end else if (n > DIGIT_MAX) begin
               r.st.phase = PH_DONE;
            end else if (s.digit_count >= COUNT_W'(MAX_PAN_DIGITS)) begin
               r.st.overflow = 1'b1;
               r.st.phase    = PH_DONE;
            end else begin
               r.wr = 1'b1;
               if (!s.digit_count[0]) begin
                  r.st.luhn_even = mod10_add(s.luhn_even, dbl);
                  r.st.luhn_odd  = mod10_add(s.luhn_odd, n);
               end else begin
                  r.st.luhn_even = mod10_add(s.luhn_even, n);
                  r.st.luhn_odd  = mod10_add(s.luhn_odd, dbl);
               end
               r.st.digit_count = s.digit_count + COUNT_W'(1);
            end
         end
         PH_TRAILER: begin
            if (fp < 3'(TRAILER_NIBBLES)) begin
               r.st.trailer[{fp, 2'b00} +: 4] = n;
               if (n > DIGIT_MAX) begin
                  r.st.trailer_bad = s.trailer_bad |
                     ((fp < 3'(EXPIRY_NIBBLES)) ? BAD_EXPIRY : BAD_SERVICE);
               end
               r.st.field_pos = fp + 3'd1;
            end
            if (r.st.field_pos >= 3'(TRAILER_NIBBLES)) begin
               r.st.phase = PH_DONE;
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

endpackage

@@ hdl/track2_nibble_parser_luhn.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// track2_nibble_parser_luhn
// Track 2 byte parser: account number with Luhn check, expiry, service code.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel req_*: one Track 2 byte per beat, high nibble first, with
//   a last flag on the final byte of the field. Output channel rsp_*: one
//   result beat per record, produced for the byte marked last.
//   Both channels: a beat moves on a clock edge with valid high, stall low.
//   A last byte is loaded into the input register, then parsed, and its
//   result is loaded into the result register that drives rsp_*.
//   Throughput: one byte per cycle while req_stall is low; both nibbles of
//   a byte are parsed combinationally between input and state/result registers.
//   Reset (synchronous, active high) empties both registers and clears the
//   record to the account-digit phase.
//   A stalled result holds; bytes without last keep flowing past it, and a
//   last byte waits in the input register, stalling req_, until it drains.
// ----------------------------------------------------------------------------
module track2_nibble_parser_luhn (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  t2p_pkg::req_beat_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output t2p_pkg::rsp_beat_type rsp_data
);
   import t2p_pkg::*;

   logic           in_valid_ff;
   req_beat_type   in_data_ff;
   rec_state_type  rec_ff;
   rec_state_type  rec_in;
   pan_digits_type digits_ff;
   pan_digits_type digits_in;
   logic           rsp_valid_ff;
   rsp_beat_type   rsp_data_ff;
   rsp_beat_type   result;
   nib_step_type   step_hi;
   nib_step_type   step_lo;
   logic           advance;

   // move the held byte into the parser unless its result cannot be stored
   assign advance   = in_valid_ff &&
                      (!in_data_ff.last || !rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   // parse both nibbles and apply digit writes
   always_comb begin
      step_hi   = take_nibble(rec_ff, in_data_ff.data_byte[7:4]);
      step_lo   = take_nibble(step_hi.st, in_data_ff.data_byte[3:0]);
      rec_in    = step_lo.st;
      digits_in = digits_ff;
      for (int i = 0; i < MAX_PAN_DIGITS; i++) begin
         if (step_hi.wr && step_hi.idx == COUNT_W'(i)) begin
            digits_in[i] = in_data_ff.data_byte[7:4];
         end
         if (step_lo.wr && step_lo.idx == COUNT_W'(i)) begin
            digits_in[i] = in_data_ff.data_byte[3:0];
         end
      end
   end

   t2p_assemble u_assemble (
      .rec    (rec_in),
      .digits (digits_in),
      .result (result)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   // record state; clear after the last byte
   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff <= REC_CLEAR;
      end else if (advance) begin
         rec_ff <= in_data_ff.last ? REC_CLEAR : rec_in;
      end
      if (advance) begin
         digits_ff <= digits_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && in_data_ff.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance && in_data_ff.last) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ hdl/t2p_assemble.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t2p_assemble
// Build the result beat from the finished record: status, BCD account
// number, Luhn verdict, expiry and service code.
// ----------------------------------------------------------------------------
module t2p_assemble (
   input  t2p_pkg::rec_state_type  rec,
   input  t2p_pkg::pan_digits_type digits,
   output t2p_pkg::rsp_beat_type   result
);
   import t2p_pkg::*;

   logic       ok;
   logic [3:0] luhn_sum;
   logic [6:0] month;
   logic [6:0] year;
   logic       exp_ok;
   logic       svc_ok;

   always_comb begin
      result = '0;

      // classify the account number
      if (rec.overflow) begin
         result.status = ST_LONG;
      end else if (rec.digit_count < COUNT_W'(MIN_PAN_DIGITS)) begin
         result.status = ST_SHORT;
      end else begin
         result.status = ST_OK;
      end
      ok = (result.status == ST_OK);
      result.pan_length = rec.digit_count;

      // pack kept digits, zero beyond the count
      for (int i = 0; i < MAX_PAN_DIGITS; i++) begin
         if (COUNT_W'(i) < rec.digit_count) begin
            if (i < 16) begin
               result.pan_bcd_low[60-4*i +: 4] = digits[i];
            end else begin
               result.pan_bcd_high[8-4*(i-16) +: 4] = digits[i];
            end
         end
      end

      // pick the sum whose doubled parity matches the final length
      luhn_sum = rec.digit_count[0] ? rec.luhn_odd : rec.luhn_even;
      result.luhn_ok = ok && (rec.digit_count >= COUNT_W'(2)) && (luhn_sum == 4'd0);

      result.separator_seen = rec.separator;

      // expiry YYMM, month 1..12
      month  = times_ten(rec.trailer[11:8]) + 7'(rec.trailer[15:12]);
      year   = times_ten(rec.trailer[3:0]) + 7'(rec.trailer[7:4]);
      exp_ok = ok && rec.separator && (rec.field_pos >= 3'(EXPIRY_NIBBLES)) &&
               !rec.trailer_bad[0] && (month >= 7'd1) && (month <= 7'(MONTH_MAX));
      result.expiry_valid = exp_ok;
      if (exp_ok) begin
         result.expiry_month = month[3:0];
         result.expiry_year  = year;
      end

      // three service digits
      svc_ok = ok && rec.separator && (rec.field_pos >= 3'(TRAILER_NIBBLES)) &&
               !rec.trailer_bad[1];
      result.service_valid = svc_ok;
      if (svc_ok) begin
         result.service_code_bcd = {rec.trailer[19:16], rec.trailer[23:20],
                                    rec.trailer[27:24]};
      end
   end

endmodule

@@ hdl/t2p_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t2p_checker
// Port-level checks on the result channel of the Track 2 parser.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module t2p_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input t2p_pkg::rsp_beat_type rsp_data
);
   import t2p_pkg::*;

   // hold a stalled result beat
   `T2P_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // a failed account number carries no check results
   `T2P_ASSERT_NOW(a_fail_clean, clock, reset, rsp_valid && rsp_data.status != ST_OK, !rsp_data.luhn_ok && !rsp_data.expiry_valid && !rsp_data.service_valid)

   // expiry and service need the separator
   `T2P_ASSERT_NOW(a_sep_needed, clock, reset, rsp_valid && !rsp_data.separator_seen, !rsp_data.expiry_valid && !rsp_data.service_valid)

   // an invalid expiry reads as zero, a valid one has a real month
   `T2P_ASSERT_NOW(a_expiry_form, clock, reset, rsp_valid, rsp_data.expiry_valid ? (rsp_data.expiry_month != 4'd0 && rsp_data.expiry_month <= 4'd12) : (rsp_data.expiry_month == 4'd0 && rsp_data.expiry_year == 7'd0))

   // an ok status only with 8 to 19 account digits
   `T2P_ASSERT_NOW(a_len_status, clock, reset, rsp_valid && rsp_data.status == ST_OK, rsp_data.pan_length >= 5'd8 && rsp_data.pan_length <= 5'd19)

endmodule

bind track2_nibble_parser_luhn t2p_checker u_t2p_checker (.*);
